FILE: src/cmag_pkg.sv
// Shared constants, tables and types of the complex magnitude and angle converter.
`timescale 1ns / 1ps

package cmag_pkg;

    // Sample width and number of angle rotations.
    localparam int DATA_WIDTH    = 16;
    localparam int CORDIC_STAGES = 16;

    // The arctangent table has a fixed length; rotations beyond it are not built.
    localparam int ATAN_LEN = 24;
    localparam int CORDIC_N = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    // Fixed-point formats: vector scaled by 2^16, angle in units of 2^-23 degree.
    localparam int FRAC_SHIFT = 16;
    localparam int XY_WIDTH   = DATA_WIDTH + FRAC_SHIFT + 3;
    localparam int Z_WIDTH    = 33;
    localparam int ANG_WIDTH  = 16;
    localparam int ANG_WIDE   = Z_WIDTH - FRAC_SHIFT;

    // Square root datapath.
    localparam int SUM_WIDTH = 2 * DATA_WIDTH;
    localparam int REM_WIDTH = DATA_WIDTH + 2;

    // Index of the last pipeline stage of the back end.
    localparam int STG_LAST = (CORDIC_N > DATA_WIDTH + 1) ? CORDIC_N : DATA_WIDTH + 1;

    // Queue depths (powers of two).
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Angle constants.
    localparam logic [Z_WIDTH-1:0]  DEG180_FX     = Z_WIDTH'(64'd1509949440);
    localparam logic [Z_WIDTH-1:0]  ROUND_HALF    = Z_WIDTH'(2 ** (FRAC_SHIFT - 1));
    localparam logic [ANG_WIDE-1:0] FULL_TURN_OUT = ANG_WIDE'(46080);

    // atan(2^-i) in units of 2^-23 degree, rounded to nearest.
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd377487360, 32'd222843801, 32'd117744544, 32'd59768969,
        32'd30000467,  32'd15014858,  32'd7509261,   32'd3754860,
        32'd1877459,   32'd938733,    32'd469367,    32'd234683,
        32'd117342,    32'd58671,     32'd29335,     32'd14668,
        32'd7334,      32'd3667,      32'd1833,      32'd917,
        32'd458,       32'd229,       32'd115,       32'd57
    };

    // Classified sample as it waits between front and back end.
    typedef struct packed {
        logic                         undef;
        logic                         neg;
        logic [DATA_WIDTH-1:0]        abs_re;
        logic [DATA_WIDTH-1:0]        abs_im;
        logic signed [DATA_WIDTH:0]   y0;
    } t_fword;

    // Contents of one back-end pipeline stage.
    typedef struct packed {
        logic                         undef;
        logic signed [XY_WIDTH-1:0]   x;
        logic signed [XY_WIDTH-1:0]   y;
        logic signed [Z_WIDTH-1:0]    z;
        logic [SUM_WIDTH-1:0]         sq_re;
        logic [SUM_WIDTH-1:0]         sq_im;
        logic [SUM_WIDTH-1:0]         rad;
        logic [REM_WIDTH-1:0]         rem;
        logic [DATA_WIDTH-1:0]        root;
    } t_stage;

    // One finished result word.
    typedef struct packed {
        logic [DATA_WIDTH-1:0]        magnitude;
        logic [ANG_WIDTH-1:0]         angle_deg;
        logic                         angle_undefined;
    } t_result;

endpackage

FILE: src/cmag_front.sv
// Front end: takes sample words, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module cmag_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  logic signed [cmag_pkg::DATA_WIDTH-1:0] i_real_part,
    input  logic signed [cmag_pkg::DATA_WIDTH-1:0] i_imag_part,
    input  logic                                   i_pop,
    output logic                                   o_valid,
    output cmag_pkg::t_fword                       o_word
);
    import cmag_pkg::*;

    t_fword                    n_word;
    logic signed [DATA_WIDTH:0] im_ext;
    logic                      wr;
    logic                      rd;

    t_fword                    r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0]          r_wp;
    logic [FQ_AW-1:0]          r_rp;
    logic [FQ_CW-1:0]          r_cnt;

    // Classification: fold the left half plane onto the right one and flag a zero sample.
    assign im_ext = {i_imag_part[DATA_WIDTH-1], i_imag_part};

    always_comb begin
        n_word.neg    = i_real_part[DATA_WIDTH-1];
        n_word.undef  = (i_real_part == '0) && (i_imag_part == '0);
        n_word.abs_re = i_real_part[DATA_WIDTH-1] ? DATA_WIDTH'(-i_real_part) : i_real_part;
        n_word.abs_im = i_imag_part[DATA_WIDTH-1] ? DATA_WIDTH'(-i_imag_part) : i_imag_part;
        n_word.y0     = i_real_part[DATA_WIDTH-1] ? -im_ext : im_ext;
    end

    // Queue handshake.
    assign o_full  = (r_cnt == FQ_CW'(FQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;
    assign o_word  = r_mem[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= n_word;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + FQ_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + FQ_AW'(1);
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + FQ_CW'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - FQ_CW'(1);
            end
        end
    end

endmodule

FILE: src/cmag_back.sv
// Back end: CORDIC vectoring and square root pipeline with a small result queue.
`timescale 1ns / 1ps

module cmag_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  cmag_pkg::t_fword   i_word,
    output logic               o_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output cmag_pkg::t_result  o_result
);
    import cmag_pkg::*;

    logic                  adv;
    logic                  oq_full;
    logic                  oq_wr;
    logic                  oq_rd;
    t_stage                n_stg0;
    t_stage                fin;
    t_result               n_res;
    logic [Z_WIDTH-1:0]    z_rnd;
    logic [ANG_WIDE-1:0]   ang_t;
    logic [ANG_WIDE-1:0]   ang_w;
    logic [ANG_WIDE-1:0]   ang_f;

    t_stage                r_stg [STG_LAST+1];
    logic [STG_LAST:0]     r_vld;
    t_result               r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0]      r_oq_wp;
    logic [OQ_AW-1:0]      r_oq_rp;
    logic [OQ_CW-1:0]      r_oq_cnt;

    // The whole pipeline moves unless its last stage holds a word that cannot leave.
    assign oq_full = (r_oq_cnt == OQ_CW'(OQ_DEPTH));
    assign adv     = !r_vld[STG_LAST] || !oq_full;
    assign o_pop   = adv && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[STG_LAST-1:0], i_valid};
        end
    end

    // Stage 0: scale the vector, seed the angle and square both components.
    always_comb begin
        n_stg0.undef = i_word.undef;
        n_stg0.x     = XY_WIDTH'(signed'({1'b0, i_word.abs_re})) <<< FRAC_SHIFT;
        n_stg0.y     = XY_WIDTH'(i_word.y0) <<< FRAC_SHIFT;
        n_stg0.z     = i_word.neg ? signed'(DEG180_FX) : '0;
        n_stg0.sq_re = SUM_WIDTH'(i_word.abs_re) * SUM_WIDTH'(i_word.abs_re);
        n_stg0.sq_im = SUM_WIDTH'(i_word.abs_im) * SUM_WIDTH'(i_word.abs_im);
        n_stg0.rad   = '0;
        n_stg0.rem   = '0;
        n_stg0.root  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_stg[0] <= n_stg0;
        end
    end

    // Stages 1 and up: rotation k-1, the sum of squares in stage 1, root digit k-2.
    for (genvar k = 1; k <= STG_LAST; k++) begin : g_stg
        t_stage                     p;
        t_stage                     n_s;
        logic signed [XY_WIDTH-1:0] px;
        logic signed [XY_WIDTH-1:0] py;
        logic signed [XY_WIDTH-1:0] x_n;
        logic signed [XY_WIDTH-1:0] y_n;
        logic signed [Z_WIDTH-1:0]  z_n;
        logic [SUM_WIDTH-1:0]       rad_n;
        logic [REM_WIDTH-1:0]       rem_n;
        logic [DATA_WIDTH-1:0]      root_n;

        assign p  = r_stg[k-1];
        assign px = p.x;
        assign py = p.y;

        if (k <= CORDIC_N) begin : g_rot
            localparam int SH = k - 1;
            localparam logic signed [Z_WIDTH-1:0] ANG = signed'(Z_WIDTH'(ATAN_TAB[k-1]));
            logic signed [XY_WIDTH-1:0] xs;
            logic signed [XY_WIDTH-1:0] ys;

            assign xs = px >>> SH;
            assign ys = py >>> SH;

            // Turn towards the real axis; a vector already on it stays put.
            always_comb begin
                x_n = px;
                y_n = py;
                z_n = p.z;
                if (py[XY_WIDTH-1]) begin
                    x_n = px - ys;
                    y_n = py + xs;
                    z_n = p.z - ANG;
                end else if (py != '0) begin
                    x_n = px + ys;
                    y_n = py - xs;
                    z_n = p.z + ANG;
                end
            end
        end else begin : g_rot_idle
            assign x_n = px;
            assign y_n = py;
            assign z_n = p.z;
        end

        if (k == 1) begin : g_sum
            assign rad_n  = p.sq_re + p.sq_im;
            assign rem_n  = p.rem;
            assign root_n = p.root;
        end else if (k - 2 < DATA_WIDTH) begin : g_sqrt
            logic [REM_WIDTH-1:0] remt;
            logic [REM_WIDTH-1:0] trial;

            // One root digit: bring down two radicand bits and try a one.
            assign remt  = {p.rem[REM_WIDTH-3:0], p.rad[SUM_WIDTH-1:SUM_WIDTH-2]};
            assign trial = {p.root, 2'b01};
            assign rad_n = {p.rad[SUM_WIDTH-3:0], 2'b00};

            always_comb begin
                if (remt >= trial) begin
                    rem_n  = remt - trial;
                    root_n = {p.root[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    rem_n  = remt;
                    root_n = {p.root[DATA_WIDTH-2:0], 1'b0};
                end
            end
        end else begin : g_sqrt_idle
            assign rad_n  = p.rad;
            assign rem_n  = p.rem;
            assign root_n = p.root;
        end

        always_comb begin
            n_s      = p;
            n_s.x    = x_n;
            n_s.y    = y_n;
            n_s.z    = z_n;
            n_s.rad  = rad_n;
            n_s.rem  = rem_n;
            n_s.root = root_n;
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_stg[k] <= n_s;
            end
        end
    end

    // Finishing: round the root, round and wrap the angle into one full turn.
    assign fin   = r_stg[STG_LAST];
    assign z_rnd = fin.z + ROUND_HALF;
    assign ang_t = z_rnd[Z_WIDTH-1:FRAC_SHIFT];
    assign ang_w = fin.z[Z_WIDTH-1] ? ang_t + FULL_TURN_OUT : ang_t;
    assign ang_f = (ang_w >= FULL_TURN_OUT) ? ang_w - FULL_TURN_OUT : ang_w;

    always_comb begin
        n_res.magnitude       = (fin.rem > {2'b00, fin.root}) ?
                                fin.root + DATA_WIDTH'(1) : fin.root;
        n_res.angle_deg       = fin.undef ? '0 : ang_f[ANG_WIDTH-1:0];
        n_res.angle_undefined = fin.undef;
    end

    // Result queue.
    assign oq_wr    = r_vld[STG_LAST] && !oq_full;
    assign o_empty  = (r_oq_cnt == '0);
    assign oq_rd    = i_pop && !o_empty;
    assign o_result = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (oq_wr) begin
            r_oq[r_oq_wp] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (oq_wr) begin
                r_oq_wp <= r_oq_wp + OQ_AW'(1);
            end
            if (oq_rd) begin
                r_oq_rp <= r_oq_rp + OQ_AW'(1);
            end
            if (oq_wr && !oq_rd) begin
                r_oq_cnt <= r_oq_cnt + OQ_CW'(1);
            end else if (oq_rd && !oq_wr) begin
                r_oq_cnt <= r_oq_cnt - OQ_CW'(1);
            end
        end
    end

endmodule

FILE: src/complex_magnitude_and_angle.sv
// Top level of the complex magnitude and angle converter.
//
//   Channel  Handshake        Word
//   input    push / full      real_part, imag_part (signed)
//   output   empty / pop      magnitude, angle_deg (1/128 degree), angle_undefined
//
// One word is taken per clock while the front queue is not full; the back end is a pipeline
// with at most one rotation and one root digit per stage, so throughput is one word per
// cycle while results are popped. The front queue holds four words and the result queue two.
// When the result queue is full and the last stage holds a word, the whole back end holds;
// the front queue keeps taking words until it too is full. Reset empties both queues and
// the pipeline.
`timescale 1ns / 1ps

module complex_magnitude_and_angle (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [cmag_pkg::DATA_WIDTH-1:0] i_real_part,
    input  logic signed [cmag_pkg::DATA_WIDTH-1:0] i_imag_part,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [cmag_pkg::DATA_WIDTH-1:0]        o_magnitude,
    output logic [cmag_pkg::ANG_WIDTH-1:0]         o_angle_deg,
    output logic                                   o_angle_undefined
);
    import cmag_pkg::*;

    logic    q_valid;
    logic    q_pop;
    t_fword  q_word;
    t_result res;

    // Front end with its queue.
    cmag_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_real_part (i_real_part),
        .i_imag_part (i_imag_part),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_word      (q_word)
    );

    // Back end pipeline and result queue.
    cmag_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_word   (q_word),
        .o_pop    (q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (res)
    );

    assign o_magnitude       = res.magnitude;
    assign o_angle_deg       = res.angle_deg;
    assign o_angle_undefined = res.angle_undefined;

endmodule
